// File: rtl/bcim_pkg.sv
package bcim_pkg;

  // Largest matrix extent or block size; larger register values saturate here
  localparam int unsigned MAX_EXTENT = 65536;

  // Field widths
  localparam int EXT_W   = 17;
  localparam int GRID_W  = 9;
  localparam int COORD_W = 8;
  localparam int IDX_W   = 16;
  localparam int OFS_W   = 32;

  // Configuration port
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;

  // Item pipeline: one restoring divider stage per quotient bit, then two
  // stages for the global index
  localparam int DIV_STAGES = IDX_W;
  localparam int AXIS_LAT   = DIV_STAGES + 2;
  localparam int SIDE_DLY   = AXIS_LAT - 1;

  // Register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_ROWS_TOTAL,
    REG_COLS_TOTAL,
    REG_ROW_BLOCK,
    REG_COL_BLOCK,
    REG_GRID_ROWS,
    REG_GRID_COLS,
    REG_MY_GRID_ROW,
    REG_MY_GRID_COL
  } reg_idx_t;

  // Effective per-axis distribution settings
  typedef struct packed {
    logic [EXT_W-1:0]   ext;
    logic [EXT_W-1:0]   blk;
    logic [GRID_W-1:0]  grid;
    logic [COORD_W-1:0] coord;
  } axis_cfg_t;

  // Local offset and range flag traveling beside the divider pipeline
  typedef struct packed {
    logic [OFS_W-1:0] loff;
    logic             inr;
  } side_t;

  // Local count sequencer
  typedef enum logic [2:0] {
    NR_IDLE,
    NR_LOAD,
    NR_DIV_BLK,
    NR_LOAD_GRID,
    NR_DIV_GRID,
    NR_MUL,
    NR_SUM
  } nr_state_t;

  function automatic logic [EXT_W-1:0] sat_ext(input logic [EXT_W-1:0] v);
    if (v > MAX_EXTENT) begin
      return EXT_W'(MAX_EXTENT);
    end
    return v;
  endfunction

  function automatic logic [EXT_W-1:0] eff_blk(input logic [EXT_W-1:0] v);
    logic [EXT_W-1:0] s;
    s = sat_ext(v);
    return (s == '0) ? EXT_W'(1) : s;
  endfunction

  function automatic logic [GRID_W-1:0] eff_grid(input logic [GRID_W-1:0] v);
    return (v == '0) ? GRID_W'(1) : v;
  endfunction

endpackage

// File: rtl/bcim_numroc.sv
module bcim_numroc (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  bcim_pkg::axis_cfg_t        cfg_i,
  output logic [bcim_pkg::EXT_W-1:0] count_o,
  output logic                       busy_o
);
  import bcim_pkg::*;

  localparam int IT_W = $clog2(EXT_W);

  nr_state_t        state_r, state_nxt;
  logic [EXT_W-1:0] dvd_r, dvd_nxt;     // dividend, quotient shifts in
  logic [EXT_W-1:0] rem_r, rem_nxt;     // partial remainder
  logic [EXT_W-1:0] dsr_r, dsr_nxt;     // divisor
  logic [IT_W-1:0]  it_r, it_nxt;
  logic [EXT_W-1:0] nrem_r, nrem_nxt;   // extent mod block
  logic [EXT_W-1:0] prod_r, prod_nxt;   // owned complete blocks times block
  logic [EXT_W-1:0] cnt_r, cnt_nxt;

  logic [EXT_W:0]   tmp;
  logic             ge;
  logic [EXT_W-1:0] rem_step;
  logic [EXT_W-1:0] dvd_step;
  logic [2*EXT_W-1:0] mul;
  logic [EXT_W:0]   len;
  logic             last_it;

  // One restoring division step per cycle
  always_comb begin
    tmp      = {rem_r, dvd_r[EXT_W-1]};
    ge       = (tmp >= {1'b0, dsr_r});
    rem_step = ge ? EXT_W'(tmp - {1'b0, dsr_r}) : tmp[EXT_W-1:0];
    dvd_step = {dvd_r[EXT_W-2:0], ge};
    last_it  = (it_r == IT_W'(EXT_W-1));
    mul      = (2*EXT_W)'(dvd_r) * (2*EXT_W)'(cfg_i.blk);
    len      = {1'b0, prod_r}
             + ((rem_r > EXT_W'(cfg_i.coord)) ? {1'b0, cfg_i.blk} : '0)
             + (((nrem_r != '0) && (rem_r == EXT_W'(cfg_i.coord))) ?
                {1'b0, nrem_r} : '0);
  end

  // Sequencer: extent / block, then complete blocks / grid, then length
  always_comb begin
    state_nxt = state_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    dsr_nxt   = dsr_r;
    it_nxt    = it_r;
    nrem_nxt  = nrem_r;
    prod_nxt  = prod_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      NR_IDLE: ;
      NR_LOAD: begin
        dvd_nxt   = cfg_i.ext;
        rem_nxt   = '0;
        dsr_nxt   = cfg_i.blk;
        it_nxt    = '0;
        state_nxt = NR_DIV_BLK;
      end
      NR_DIV_BLK: begin
        dvd_nxt = dvd_step;
        rem_nxt = rem_step;
        it_nxt  = it_r + IT_W'(1);
        if (last_it) begin
          state_nxt = NR_LOAD_GRID;
        end
      end
      NR_LOAD_GRID: begin
        nrem_nxt  = rem_r;
        rem_nxt   = '0;
        dsr_nxt   = EXT_W'(cfg_i.grid);
        it_nxt    = '0;
        state_nxt = NR_DIV_GRID;
      end
      NR_DIV_GRID: begin
        dvd_nxt = dvd_step;
        rem_nxt = rem_step;
        it_nxt  = it_r + IT_W'(1);
        if (last_it) begin
          state_nxt = NR_MUL;
        end
      end
      NR_MUL: begin
        prod_nxt  = mul[EXT_W-1:0];
        state_nxt = NR_SUM;
      end
      NR_SUM: begin
        cnt_nxt   = len[EXT_W-1:0];
        state_nxt = NR_IDLE;
      end
      default: state_nxt = NR_IDLE;
    endcase
    // A new register write restarts the computation
    if (start_i) begin
      state_nxt = NR_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= NR_IDLE;
      cnt_r   <= EXT_W'(1);
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    it_r   <= it_nxt;
    nrem_r <= nrem_nxt;
    prod_r <= prod_nxt;
  end

  assign count_o = cnt_r;
  assign busy_o  = (state_r != NR_IDLE);

endmodule

// File: rtl/bcim_axis.sv
module bcim_axis (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       vld_i,
  input  logic [bcim_pkg::IDX_W-1:0] li_i,
  input  bcim_pkg::axis_cfg_t        cfg_i,
  output logic                       vld_o,
  output logic [bcim_pkg::IDX_W-1:0] gi_o
);
  import bcim_pkg::*;

  // Divider stage registers
  logic             vld_r [0:DIV_STAGES-1];
  logic [EXT_W-1:0] rem_r [0:DIV_STAGES-1];
  logic [IDX_W-1:0] sh_r  [0:DIV_STAGES-1];
  logic             vld_in [0:DIV_STAGES-1];
  logic [EXT_W-1:0] rem_in [0:DIV_STAGES-1];
  logic [IDX_W-1:0] sh_in  [0:DIV_STAGES-1];
  logic [EXT_W-1:0] rem_nxt [0:DIV_STAGES-1];
  logic [IDX_W-1:0] sh_nxt  [0:DIV_STAGES-1];

  // Index stages
  logic             g1_vld_r, g2_vld_r;
  logic [IDX_W-1:0] t_r, r1_r, gi_r;
  logic [IDX_W-1:0] t_nxt, gi_nxt;
  logic [IDX_W+GRID_W-1:0] qg;
  logic [2*IDX_W-1:0]      tb;

  // Stage inputs: first stage from the ports, then from the previous stage
  genvar s;
  generate
    for (s = 0; s < DIV_STAGES; s++) begin : g_stage
      if (s == 0) begin : g_first
        assign vld_in[s] = vld_i;
        assign rem_in[s] = '0;
        assign sh_in[s]  = li_i;
      end else begin : g_rest
        assign vld_in[s] = vld_r[s-1];
        assign rem_in[s] = rem_r[s-1];
        assign sh_in[s]  = sh_r[s-1];
      end
    end
  endgenerate

  // One quotient bit per stage; sh holds dividend bits out, quotient bits in
  always_comb begin
    logic [EXT_W:0] tmp;
    logic           ge;
    for (int i = 0; i < DIV_STAGES; i++) begin
      tmp        = {rem_in[i], sh_in[i][IDX_W-1]};
      ge         = (tmp >= {1'b0, cfg_i.blk});
      rem_nxt[i] = ge ? EXT_W'(tmp - {1'b0, cfg_i.blk}) : tmp[EXT_W-1:0];
      sh_nxt[i]  = {sh_in[i][IDX_W-2:0], ge};
    end
  end

  // (block * grid + coord) * blk + offset, kept modulo 2^16
  always_comb begin
    qg     = (IDX_W+GRID_W)'(sh_r[DIV_STAGES-1]) * (IDX_W+GRID_W)'(cfg_i.grid);
    t_nxt  = IDX_W'(qg + (IDX_W+GRID_W)'(cfg_i.coord));
    tb     = (2*IDX_W)'(t_r) * (2*IDX_W)'(cfg_i.blk[IDX_W-1:0]);
    gi_nxt = IDX_W'(tb[IDX_W-1:0] + r1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        vld_r[i] <= 1'b0;
      end
      g1_vld_r <= 1'b0;
      g2_vld_r <= 1'b0;
    end else begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        vld_r[i] <= vld_in[i];
      end
      g1_vld_r <= vld_r[DIV_STAGES-1];
      g2_vld_r <= g1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      rem_r[i] <= rem_nxt[i];
      sh_r[i]  <= sh_nxt[i];
    end
    t_r  <= t_nxt;
    r1_r <= rem_r[DIV_STAGES-1][IDX_W-1:0];
    gi_r <= gi_nxt;
  end

  assign vld_o = g2_vld_r;
  assign gi_o  = gi_r;

endmodule

// File: rtl/block_cyclic_index_mapper_unit.sv
// Block-cyclic local-to-global index mapper. Takes one local (row, col)
// coordinate per cycle when start is high and busy is low, and returns the
// global row/col, the column-major global and local offsets and an in-range
// flag on out_valid, which is high for a single cycle per item; results
// cannot be held off. Items are fully pipelined: a 16-stage restoring
// divider per axis splits each index by its block size. Each register write
// recomputes the local row and column counts with a serial divider that
// takes one bit per cycle; busy stays high after a write until both are done.
module block_cyclic_index_mapper_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // Item input
  input  logic                          start,
  output logic                          busy,
  input  logic [bcim_pkg::IDX_W-1:0]    in_local_row,
  input  logic [bcim_pkg::IDX_W-1:0]    in_local_col,
  // Results
  output logic                          out_valid,
  output logic [bcim_pkg::IDX_W-1:0]    out_global_row,
  output logic [bcim_pkg::IDX_W-1:0]    out_global_col,
  output logic [bcim_pkg::OFS_W-1:0]    out_global_offset,
  output logic [bcim_pkg::OFS_W-1:0]    out_local_offset,
  output logic                          out_in_range,
  // Configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcim_pkg::ADDR_W-1:0]   paddr,
  input  logic [bcim_pkg::DATA_W-1:0]   pwdata,
  output logic [bcim_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import bcim_pkg::*;

  localparam int PIPE_LAT = AXIS_LAT + 1;

  // Configuration registers
  logic [EXT_W-1:0]   rows_total_r, cols_total_r, row_block_r, col_block_r;
  logic [GRID_W-1:0]  grid_rows_r, grid_cols_r;
  logic [COORD_W-1:0] my_grid_row_r, my_grid_col_r;

  logic      cfg_wr;
  reg_idx_t  cfg_idx;
  axis_cfg_t row_cfg, col_cfg;
  logic [EXT_W-1:0] loc_rows, loc_cols;
  logic      row_busy, col_busy;
  logic      accept;

  // Entry stage
  logic             ent_vld_r;
  logic [IDX_W-1:0] ent_lr_r, ent_lc_r;

  // Side path
  logic [OFS_W-1:0]   sd1_prod_r;
  logic [IDX_W-1:0]   sd1_lr_r;
  logic               sd1_inr_r;
  logic [IDX_W+EXT_W-1:0] lprod;
  side_t              side_r [0:SIDE_DLY-1];
  side_t              side_nxt;

  // Axis outputs
  logic             row_vld, col_vld;
  logic [IDX_W-1:0] grow, gcol;
  logic [IDX_W+EXT_W-1:0] gprod;

  // Output registers
  logic             out_valid_r;
  logic [IDX_W-1:0] grow_r, gcol_r;
  logic [OFS_W-1:0] goff_r, loff_r;
  logic             inr_r;

  // Register write decode
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_total_r  <= EXT_W'(1);
      cols_total_r  <= EXT_W'(1);
      row_block_r   <= EXT_W'(1);
      col_block_r   <= EXT_W'(1);
      grid_rows_r   <= GRID_W'(1);
      grid_cols_r   <= GRID_W'(1);
      my_grid_row_r <= '0;
      my_grid_col_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ROWS_TOTAL:  rows_total_r  <= pwdata[EXT_W-1:0];
        REG_COLS_TOTAL:  cols_total_r  <= pwdata[EXT_W-1:0];
        REG_ROW_BLOCK:   row_block_r   <= pwdata[EXT_W-1:0];
        REG_COL_BLOCK:   col_block_r   <= pwdata[EXT_W-1:0];
        REG_GRID_ROWS:   grid_rows_r   <= pwdata[GRID_W-1:0];
        REG_GRID_COLS:   grid_cols_r   <= pwdata[GRID_W-1:0];
        REG_MY_GRID_ROW: my_grid_row_r <= pwdata[COORD_W-1:0];
        REG_MY_GRID_COL: my_grid_col_r <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      REG_ROWS_TOTAL:  prdata = DATA_W'(rows_total_r);
      REG_COLS_TOTAL:  prdata = DATA_W'(cols_total_r);
      REG_ROW_BLOCK:   prdata = DATA_W'(row_block_r);
      REG_COL_BLOCK:   prdata = DATA_W'(col_block_r);
      REG_GRID_ROWS:   prdata = DATA_W'(grid_rows_r);
      REG_GRID_COLS:   prdata = DATA_W'(grid_cols_r);
      REG_MY_GRID_ROW: prdata = DATA_W'(my_grid_row_r);
      REG_MY_GRID_COL: prdata = DATA_W'(my_grid_col_r);
      default:         prdata = '0;
    endcase
  end

  // Effective per-axis settings
  always_comb begin
    row_cfg.ext   = sat_ext(rows_total_r);
    row_cfg.blk   = eff_blk(row_block_r);
    row_cfg.grid  = eff_grid(grid_rows_r);
    row_cfg.coord = my_grid_row_r;
    col_cfg.ext   = sat_ext(cols_total_r);
    col_cfg.blk   = eff_blk(col_block_r);
    col_cfg.grid  = eff_grid(grid_cols_r);
    col_cfg.coord = my_grid_col_r;
  end

  // Local extents, recomputed after each write
  bcim_numroc u_nr_row (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cfg_wr),
    .cfg_i   (row_cfg),
    .count_o (loc_rows),
    .busy_o  (row_busy)
  );

  bcim_numroc u_nr_col (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cfg_wr),
    .cfg_i   (col_cfg),
    .count_o (loc_cols),
    .busy_o  (col_busy)
  );

  assign busy   = row_busy || col_busy;
  assign accept = start && !busy;

  // Entry register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
    end else begin
      ent_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    ent_lr_r <= in_local_row;
    ent_lc_r <= in_local_col;
  end

  // Per-axis global index pipelines
  bcim_axis u_ax_row (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (ent_vld_r),
    .li_i  (ent_lr_r),
    .cfg_i (row_cfg),
    .vld_o (row_vld),
    .gi_o  (grow)
  );

  bcim_axis u_ax_col (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (ent_vld_r),
    .li_i  (ent_lc_r),
    .cfg_i (col_cfg),
    .vld_o (col_vld),
    .gi_o  (gcol)
  );

  // Side path: local offset and range flag, delayed to match the axes
  assign lprod    = (IDX_W+EXT_W)'(ent_lc_r) * (IDX_W+EXT_W)'(loc_rows);
  assign side_nxt = '{loff: OFS_W'(sd1_prod_r + OFS_W'(sd1_lr_r)), inr: sd1_inr_r};

  always_ff @(posedge clk) begin
    sd1_prod_r <= lprod[OFS_W-1:0];
    sd1_lr_r   <= ent_lr_r;
    sd1_inr_r  <= (EXT_W'(ent_lr_r) < loc_rows) && (EXT_W'(ent_lc_r) < loc_cols);
    side_r[0]  <= side_nxt;
    for (int i = 1; i < SIDE_DLY; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  // Output stage: column-major global offset
  assign gprod = (IDX_W+EXT_W)'(gcol) * (IDX_W+EXT_W)'(row_cfg.ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= row_vld && col_vld;
    end
  end

  always_ff @(posedge clk) begin
    grow_r <= grow;
    gcol_r <= gcol;
    goff_r <= OFS_W'(gprod[OFS_W-1:0] + OFS_W'(grow));
    loff_r <= side_r[SIDE_DLY-1].loff;
    inr_r  <= side_r[SIDE_DLY-1].inr;
  end

  assign out_valid         = out_valid_r;
  assign out_global_row    = grow_r;
  assign out_global_col    = gcol_r;
  assign out_global_offset = goff_r;
  assign out_local_offset  = loff_r;
  assign out_in_range      = inr_r;

  // Every result matches an earlier item in the entry register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(ent_vld_r, PIPE_LAT))
    else $error("result without matching entry");

  // A register write blocks new items on the next cycle
  a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> busy)
    else $error("busy not raised after write");

  // A settled local count never exceeds the global extent
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (loc_rows <= row_cfg.ext) && (loc_cols <= col_cfg.ext))
    else $error("local count above extent");

endmodule
